### src/lpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_pkg: shared types and constants of the LED pixel PWM serializer
// Item and result payloads, configuration set, command queue entry, opcodes
// and the color byte rotation.
// ----------------------------------------------------------------------------
package lpps_pkg;

  localparam int unsigned MaxPixels    = 32;
  localparam int unsigned PixIdxW      = 5;
  localparam int unsigned ColorW       = 24;
  localparam int unsigned DutyW        = 16;
  localparam int unsigned CountW       = 6;
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitCntW      = 5;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [CountW-1:0]  MaxPixelsCnt = CountW'(MaxPixels);
  localparam logic [BitCntW-1:0] LastBitIdx   = BitCntW'(BitsPerPixel - 1);
  localparam logic [CountW-1:0]  LedCountRst  = CountW'(32);

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OpSet  = 2'd0,
    OpFill = 2'd1,
    OpShow = 2'd2
  } lpps_op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegColorOrder = 2'd0,
    RegOneDuty    = 2'd1,
    RegZeroDuty   = 2'd2,
    RegLedCount   = 2'd3
  } lpps_reg_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StRead,
    StShow
  } lpps_state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PixIdxW-1:0] pixel_index;
    logic [ColorW-1:0]  color;
  } lpps_in_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_word;
    logic             last_bit;
  } lpps_out_t;

  typedef struct packed {
    logic              color_order;
    logic [DutyW-1:0]  one_duty;
    logic [DutyW-1:0]  zero_duty;
    logic [CountW-1:0] led_count;
  } lpps_cfg_t;

  // Classified command passed from front to back
  typedef struct packed {
    lpps_op_e           op;
    logic [PixIdxW-1:0] idx;
    logic [ColorW-1:0]  pix;
    logic [CountW-1:0]  count;
  } lpps_cmd_t;

  // Rotate color bytes right by one byte (low byte to the top) when color_order is set
  function automatic logic [ColorW-1:0] apply_order(input logic order,
                                                    input logic [ColorW-1:0] c);
    logic [ColorW-1:0] r;
    r = order ? {c[7:0], c[23:16], c[15:8]} : c;
    return r;
  endfunction

endpackage

### src/lpps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpps_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/lpps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_front: item intake and command queue
// Accepts items, drops unused opcodes, applies color order and fill count
// saturation, and buffers commands in a two entry queue.
// ----------------------------------------------------------------------------
module lpps_front
  import lpps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  lpps_in_t  item_i,
  output logic      busy_o,
  input  lpps_cfg_t cfg_i,
  output logic      cmd_valid_o,
  output lpps_cmd_t cmd_o,
  input  logic      cmd_ready_i
);

  logic      wr_ptr_q, wr_ptr_d;
  logic      rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  lpps_cmd_t  slot_q [2];
  lpps_cmd_t  cmd_new;
  logic       known_op;
  logic       push, pop;
  logic [CountW-1:0] fill_cnt;

  // Classify the incoming item
  always_comb begin
    fill_cnt = (cfg_i.led_count > MaxPixelsCnt) ? MaxPixelsCnt : cfg_i.led_count;
    known_op = 1'b1;
    cmd_new.op = OpSet;
    unique case (item_i.operation)
      OpSet:   cmd_new.op = OpSet;
      OpFill:  cmd_new.op = OpFill;
      OpShow:  cmd_new.op = OpShow;
      default: known_op = 1'b0;
    endcase
    cmd_new.idx   = item_i.pixel_index;
    cmd_new.pix   = apply_order(cfg_i.color_order, item_i.color);
    cmd_new.count = fill_cnt;
  end

  assign busy_o      = cnt_q[1];
  assign push        = start_i && !busy_o && known_op;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_ptr_q];

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue changed without a pop");

endmodule

### src/lpps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_back: command execution
// Writes the pixel store for set and fill, reads a pixel for show and
// streams its 24 duty words, most significant bit first.
// ----------------------------------------------------------------------------
module lpps_back
  import lpps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lpps_cfg_t cfg_i,
  input  logic      cmd_valid_i,
  input  lpps_cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      out_valid_o,
  output lpps_out_t result_o
);

  lpps_state_e state_q, state_d;
  logic [ColorW-1:0]  pix_q, pix_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  fill_cnt_q, fill_cnt_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [MaxPixels-1:0] valid_q, valid_d;
  logic rd_valid_q, rd_valid_d;
  logic out_valid_q, out_valid_d;
  lpps_out_t result_q, result_d;
  logic pop, in_range;
  logic ram_we;
  logic [PixIdxW-1:0] ram_waddr;
  logic [ColorW-1:0]  ram_wdata, ram_rdata;

  assign cmd_ready_o = (state_q == StIdle);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign in_range    = ({1'b0, cmd_i.idx} < MaxPixelsCnt);

  lpps_ram #(
    .Width(ColorW),
    .Depth(MaxPixels)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cmd_i.idx),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (pop) begin
          if (cmd_i.op == OpFill && cmd_i.count != '0) begin
            state_d = StFill;
          end else if (cmd_i.op == OpShow) begin
            state_d = StRead;
          end
        end
      end
      StFill: begin
        if (fill_cnt_q + CountW'(1) == count_q) begin
          state_d = StIdle;
        end
      end
      StRead: state_d = StShow;
      StShow: begin
        if (bit_q == LastBitIdx) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and store control
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cmd_i.idx;
    ram_wdata   = cmd_i.pix;
    pix_d       = pix_q;
    count_d     = count_q;
    fill_cnt_d  = fill_cnt_q;
    bit_d       = bit_q;
    valid_d     = valid_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = 1'b0;
    result_d    = result_q;
    unique case (state_q)
      StIdle: begin
        if (pop) begin
          pix_d      = cmd_i.pix;
          count_d    = cmd_i.count;
          fill_cnt_d = '0;
          bit_d      = '0;
          rd_valid_d = in_range && valid_q[cmd_i.idx];
          if (cmd_i.op == OpSet && in_range) begin
            ram_we              = 1'b1;
            valid_d[cmd_i.idx]  = 1'b1;
          end
        end
      end
      StFill: begin
        ram_we     = 1'b1;
        ram_waddr  = fill_cnt_q[PixIdxW-1:0];
        ram_wdata  = pix_q;
        valid_d[fill_cnt_q[PixIdxW-1:0]] = 1'b1;
        fill_cnt_d = fill_cnt_q + CountW'(1);
      end
      StRead: begin
        pix_d = rd_valid_q ? ram_rdata : '0;
      end
      StShow: begin
        out_valid_d        = 1'b1;
        result_d.duty_word = pix_q[ColorW-1] ? cfg_i.one_duty : cfg_i.zero_duty;
        result_d.last_bit  = (bit_q == LastBitIdx);
        pix_d              = {pix_q[ColorW-2:0], 1'b0};
        bit_d              = bit_q + BitCntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      fill_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      fill_cnt_q  <= fill_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    count_q    <= count_d;
    rd_valid_q <= rd_valid_d;
    result_q   <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  a_out_from_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(state_q == StShow))
    else $error("result strobe without a show cycle");

  a_no_write_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && (state_q == StShow || state_q == StRead)))
    else $error("store written during a show");

  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShow) |-> (bit_q <= LastBitIdx))
    else $error("bit counter past the last bit");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.last_bit) |-> state_q == StIdle)
    else $error("last word did not end the show");

endmodule

### src/led_pixel_pwm_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_pwm_serializer: pixel store with PWM bit encoder
// Holds 32 pixel colors and turns a shown pixel into 24 PWM duty words.
// ----------------------------------------------------------------------------
// Usage:
//   Items are transferred on start_i while busy_o is low. item_i carries the
//   operation (set, fill, show), a pixel index and a 24-bit color. Unused
//   opcode 3 is accepted and dropped.
//   Items enter a two entry queue; busy_o rises only when that queue is full.
//   A set is done by the back end as it takes the command; a fill then
//   writes led_count pixels from index 0, with led_count capped at 32 (one
//   store write per cycle through the single RAM write port), a show makes
//   one read request, one registered RAM read, then streams 24 words.
//   A show's first word passes the RAM read, pix_q and result registers in turn.
//   Results are strobed by out_valid_o for one cycle each on result_o; the
//   receiver cannot stall, so every strobed word is a transfer.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; the user writes only while the block is idle (unenforced).
//   Reset clears control state, color order, duties and per pixel valid
//   bits and sets led_count to 32; every pixel then reads as zero.
// ----------------------------------------------------------------------------
module led_pixel_pwm_serializer
  import lpps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lpps_in_t            item_i,
  output logic                busy_o,
  output logic                out_valid_o,
  output lpps_out_t           result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  lpps_cfg_t cfg_q, cfg_d;
  lpps_cmd_t cmd;
  logic      cmd_valid, cmd_ready;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lpps_reg_e'(cfg_idx_i))
        RegColorOrder: cfg_d.color_order = cfg_data_i[0];
        RegOneDuty:    cfg_d.one_duty    = cfg_data_i[DutyW-1:0];
        RegZeroDuty:   cfg_d.zero_duty   = cfg_data_i[DutyW-1:0];
        RegLedCount:   cfg_d.led_count   = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_order <= 1'b0;
      cfg_q.one_duty    <= '0;
      cfg_q.zero_duty   <= '0;
      cfg_q.led_count   <= LedCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lpps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .cfg_i      (cfg_q),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  lpps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .out_valid_o(out_valid_o),
    .result_o   (result_o)
  );

endmodule
